// ===== src/frgcd_pkg.sv =====
`timescale 1ns / 1ps

package frgcd_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture an input item
    logic gcd_step;   // one binary gcd step
    logic latch_g;    // take the finished gcd as divisor
    logic div_init;   // start a division
    logic div_den;    // division works on the denominator magnitude
    logic div_step;   // one restoring division step
    logic save_num;   // keep the numerator quotient
    logic commit;     // move the result into the output registers
  } frgcd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic special;    // zero numerator or zero denominator
    logic gcd_done;   // one gcd operand has reached zero
  } frgcd_stat_t;

endpackage

// ===== src/fraction_reduce_gcd_core.sv =====
// fraction_reduce_gcd_core: reduces a signed fraction to lowest terms
//
// input channel: in_valid/in_ready with in_numerator and in_denominator,
// both two's complement. result channel: out_valid/out_ready with
// out_reduced_numerator (signed, carries the sign), out_reduced_denominator
// (positive) and out_zero_denominator. a zero denominator gives 0/1 with
// the flag set, a zero numerator gives 0/1 with the flag clear.
//
// one item is worked on at a time by a shared datapath: a binary gcd that
// takes one step a cycle (at most 2*WIDTH steps), then two restoring
// divisions by the same divider, first of the numerator magnitude and
// then of the denominator magnitude. zero inputs skip the gcd and the
// divisions. the next item is taken in the cycle after the commit, so
// no new item is taken while the last one is still in work.
//
// the result sits in its own output register, so a new item is accepted
// while the previous result waits for out_ready. if the receiver stalls,
// the finished item waits in the controller until the output register
// frees up. reset (rst_n low, synchronous) empties the block.
`timescale 1ns / 1ps

module fraction_reduce_gcd_core
  import frgcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WIDTH-1:0]  in_numerator,
  input  logic [WIDTH-1:0]  in_denominator,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WIDTH-1:0]  out_reduced_numerator,
  output logic [WIDTH-2:0]  out_reduced_denominator,
  output logic              out_zero_denominator
);

  frgcd_cmd_t  cmd;
  frgcd_stat_t stat;

  // sequencing: gcd loop, numerator division, denominator division, commit
  frgcd_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // magnitudes, gcd registers, shared divider and output registers
  frgcd_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk             (clk),
    .in_numerator    (in_numerator),
    .in_denominator  (in_denominator),
    .cmd             (cmd),
    .stat            (stat),
    .res_numerator   (out_reduced_numerator),
    .res_denominator (out_reduced_denominator),
    .res_zero_den    (out_zero_denominator)
  );

  // a flagged zero denominator always reads as 0/1
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_denominator |->
      out_reduced_numerator == '0 && out_reduced_denominator == (WIDTH-1)'(1))
    else $error("zero denominator result is not 0/1");

  // the denominator of a result is never zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reduced_denominator != '0)
    else $error("reduced denominator is zero");

  // one item at a time: after an accept the input side is closed
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

endmodule

// ===== src/frgcd_ctrl.sv =====
`timescale 1ns / 1ps

module frgcd_ctrl
  import frgcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  frgcd_stat_t stat,
  output frgcd_cmd_t  cmd
);

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIVN,
    S_MID,
    S_DIVD,
    S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            last_step;

  assign last_step = (cnt_r == CW'(WIDTH - 1));
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.special) begin
          state_nxt = S_DONE;
        end else if (stat.gcd_done) begin
          cmd.latch_g  = 1'b1;
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        cmd.save_num = 1'b1;
        cmd.div_init = 1'b1;
        cmd.div_den  = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIVD;
      end
      S_DIVD: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/frgcd_datapath.sv =====
`timescale 1ns / 1ps

module frgcd_datapath
  import frgcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic [WIDTH-1:0]  in_numerator,
  input  logic [WIDTH-1:0]  in_denominator,
  input  frgcd_cmd_t        cmd,
  output frgcd_stat_t       stat,
  output logic [WIDTH-1:0]  res_numerator,
  output logic [WIDTH-2:0]  res_denominator,
  output logic              res_zero_den
);

  localparam int CW = $clog2(WIDTH);
  localparam logic [WIDTH-1:0] MAX_MAG = {1'b0, {(WIDTH-1){1'b1}}};

  logic [WIDTH-1:0] a_r, b_r, nmag_r, dmag_r, g_r, rem_r, quo_r, qn_r;
  logic [CW-1:0]    k_r;
  logic             neg_r, zd_r, zn_r;
  logic [WIDTH-1:0] out_num_r;
  logic [WIDTH-2:0] out_den_r;
  logic             out_zd_r;

  logic             nneg, dneg;
  logic [WIDTH-1:0] nmag, dmag;
  logic [WIDTH-1:0] diff_ab, diff_ba;
  logic             a_ge_b;
  logic [WIDTH:0]   shifted, trial;
  logic             fits;
  logic [WIDTH-1:0] qn_sat, qd_sat;

  assign nneg = in_numerator[WIDTH-1];
  assign dneg = in_denominator[WIDTH-1];
  // most negative value maps to magnitude 2^(WIDTH-1) as unsigned
  assign nmag = nneg ? (~in_numerator + 1'b1) : in_numerator;
  assign dmag = dneg ? (~in_denominator + 1'b1) : in_denominator;

  assign a_ge_b  = (a_r >= b_r);
  assign diff_ab = a_r - b_r;
  assign diff_ba = b_r - a_r;

  assign shifted = {rem_r, quo_r[WIDTH-1]};
  assign trial   = shifted - {1'b0, g_r};
  assign fits    = ~trial[WIDTH];

  assign qn_sat = qn_r[WIDTH-1]  ? MAX_MAG : qn_r;
  assign qd_sat = quo_r[WIDTH-1] ? MAX_MAG : quo_r;

  assign stat.special  = zd_r || zn_r;
  assign stat.gcd_done = (a_r == '0) || (b_r == '0);

  assign res_numerator   = out_num_r;
  assign res_denominator = out_den_r;
  assign res_zero_den    = out_zd_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= nmag;
      b_r    <= dmag;
      nmag_r <= nmag;
      dmag_r <= dmag;
      k_r    <= '0;
      neg_r  <= nneg ^ dneg;
      zd_r   <= (dmag == '0);
      zn_r   <= (nmag == '0);
    end
    // binary gcd: strip common twos, halve a lone even operand, else halve the difference of two odds
    if (cmd.gcd_step) begin
      if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_ge_b) begin
        a_r <= diff_ab >> 1;
      end else begin
        b_r <= diff_ba >> 1;
      end
    end
    if (cmd.latch_g) begin
      g_r <= (a_r | b_r) << k_r;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= cmd.div_den ? dmag_r : nmag_r;
    end
    // restoring division, one quotient bit per step
    if (cmd.div_step) begin
      rem_r <= fits ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_r <= {quo_r[WIDTH-2:0], fits};
    end
    if (cmd.save_num) begin
      qn_r <= quo_r;
    end
    if (cmd.commit) begin
      out_zd_r <= zd_r;
      if (zd_r || zn_r) begin
        out_num_r <= '0;
        out_den_r <= (WIDTH-1)'(1);
      end else begin
        out_num_r <= neg_r ? (~qn_sat + 1'b1) : qn_sat;
        out_den_r <= qd_sat[WIDTH-2:0];
      end
    end
  end

endmodule

// ===== tb/fraction_reduce_gcd_core_test.sv =====
`timescale 1ns / 1ps

module fraction_reduce_gcd_core_test;
  import frgcd_pkg::*;

  localparam int W = 32;
  // largest magnitude a reduced field can carry
  localparam logic [W-1:0] MAX_MAG = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  // covers the worst-case run of one item plus margin
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SEGMENT_ITEMS = 150;
  localparam int SEGMENTS = 12;

  // what the offer queue carries: fractions and a few sequencing markers
  typedef enum logic [1:0] {
    ENTRY_PAIR,   // a fraction to send
    ENTRY_DRAIN,  // sender waits until every result is back
    ENTRY_HOLD,   // receiver starts one long hold-off
    ENTRY_QUIET   // no more idling on either side
  } entry_kind_e;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_HEAVY
  } idle_mode_e;

  typedef struct packed {
    entry_kind_e    kind;
    logic [W-1:0]   num;
    logic [W-1:0]   den;
    logic [3:0]     gap;   // idle cycles before the item is offered
  } entry_t;

  typedef struct packed {
    logic [W-1:0]   num;
    logic [W-2:0]   den;
    logic           zero_den;
  } lowest_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [W-1:0]     in_numerator = '0;
  logic [W-1:0]     in_denominator = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [W-1:0]     out_reduced_numerator;
  logic [W-2:0]     out_reduced_denominator;
  logic             out_zero_denominator;

  entry_t           fraction_q[$];     // items still to be offered
  lowest_t          lowest_terms_q[$]; // predicted results, oldest first
  entry_t           staged;
  logic             staged_live = 1'b0;
  logic             in_fire = 1'b0;    // item taken at the last rising edge
  logic             quiet_tail = 1'b0;
  int               hold_asked = 0;
  int               hold_served = 0;
  int               hold_left = 0;
  int               rx_gap = 0;
  int               rx_cycle = 0;
  idle_mode_e       rx_mode = IDLE_NONE;
  lowest_t          want;
  int               errors = 0;
  int               n_sent = 0;
  int               n_checked = 0;
  int               n_zero_den = 0;
  int               n_zero_num = 0;
  int               n_most_neg = 0;

  fraction_reduce_gcd_core #(
    .WIDTH(W)
  ) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_numerator            (in_numerator),
    .in_denominator          (in_denominator),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_reduced_numerator   (out_reduced_numerator),
    .out_reduced_denominator (out_reduced_denominator),
    .out_zero_denominator    (out_zero_denominator)
  );

  // lowest terms by euclid on the magnitudes, sign moved to the numerator
  function automatic lowest_t reduce_fraction(input logic [W-1:0] num,
                                               input logic [W-1:0] den);
    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] rem;
    logic [W-1:0] q_num;
    logic [W-1:0] q_den;
    lowest_t      r;
    // the most negative value comes out as magnitude 2^(W-1), unsigned
    num_mag = num[W-1] ? ~num + 1'b1 : num;
    den_mag = den[W-1] ? ~den + 1'b1 : den;
    r.num = '0;
    r.den = (W-1)'(1);
    r.zero_den = 1'b0;
    if (den_mag == 0) begin
      r.zero_den = 1'b1;
    end else if (num_mag != 0) begin
      a = num_mag;
      b = den_mag;
      while (b != 0) begin
        rem = a % b;
        a = b;
        b = rem;
      end
      q_num = num_mag / a;
      q_den = den_mag / a;
      // a quotient of 2^(W-1) does not fit, clamp it
      if (q_num > MAX_MAG) q_num = MAX_MAG;
      if (q_den > MAX_MAG) q_den = MAX_MAG;
      r.num = (num[W-1] ^ den[W-1]) ? ~q_num + 1'b1 : q_num;
      r.den = q_den[W-2:0];
    end
    return r;
  endfunction

  function automatic logic [3:0] pick_gap(input idle_mode_e mode);
    logic [3:0] g;
    g = '0;
    case (mode)
      IDLE_LIGHT: begin
        if ($urandom_range(0, 9) == 0) g = 4'($urandom_range(1, 8));
      end
      IDLE_HEAVY: begin
        if ($urandom_range(0, 2) == 0) g = 4'($urandom_range(1, 8));
      end
      default: g = '0;
    endcase
    return g;
  endfunction

  task automatic add_pair(input logic [W-1:0] num, input logic [W-1:0] den,
                          input logic [3:0] gap);
    entry_t e;
    e.kind = ENTRY_PAIR;
    e.num = num;
    e.den = den;
    e.gap = gap;
    fraction_q.push_back(e);
  endtask

  task automatic add_marker(input entry_kind_e kind);
    entry_t e;
    e = '0;
    e.kind = kind;
    fraction_q.push_back(e);
  endtask

  function automatic logic [W-1:0] maybe_negate(input logic [W-1:0] v);
    return $urandom_range(0, 1) ? ~v + 1'b1 : v;
  endfunction

  // random fraction, weighted toward shared factors and the corner values
  task automatic random_fraction(output logic [W-1:0] num, output logic [W-1:0] den);
    int kg;
    int ka;
    int kb;
    logic [W-1:0] g;
    int pick;
    pick = $urandom_range(0, 15);
    num = $urandom;
    den = $urandom;
    case (pick)
      0, 1, 2, 3: begin
        // raw bits, mostly coprime
      end
      4, 5, 6, 7, 8: begin
        // shared factor of up to 16 bits, product stays in range
        kg = $urandom_range(1, 16);
        ka = $urandom_range(1, W - 1 - kg);
        kb = $urandom_range(1, W - 1 - kg);
        g = $urandom_range(1, (1 << kg) - 1);
        num = maybe_negate(($urandom & ({W{1'b1}} >> (W - ka))) * g);
        den = maybe_negate(($urandom & ({W{1'b1}} >> (W - kb))) * g);
      end
      9, 10: begin
        num = $urandom_range(0, 32) - 16;
        den = $urandom_range(0, 32) - 16;
      end
      11: begin
        // powers of two stress the even/odd paths of a binary gcd
        num = maybe_negate($urandom_range(1, 255) << $urandom_range(0, 23));
        den = maybe_negate($urandom_range(1, 255) << $urandom_range(0, 23));
      end
      12: begin
        num = $urandom_range(0, 1) ? den : ~den + 1'b1;
      end
      13: begin
        if ($urandom_range(0, 1)) num = '0;
        else den = '0;
      end
      14: begin
        case ($urandom_range(0, 2))
          0: num = MOST_NEG;
          1: den = MOST_NEG;
          default: begin
            num = MOST_NEG;
            den = MOST_NEG;
          end
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0: num = maybe_negate(1);
          1: den = maybe_negate(1);
          2: num = maybe_negate(MAX_MAG);
          default: den = maybe_negate(MAX_MAG);
        endcase
      end
    endcase
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // driver: one item in flight on the input port, held until taken
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (!staged_live && fraction_q.size() != 0) begin
        staged = fraction_q.pop_front();
        staged_live = 1'b1;
      end
      if (!staged_live) begin
        in_valid <= 1'b0;
      end else begin
        case (staged.kind)
          ENTRY_DRAIN: begin
            in_valid <= 1'b0;
            if (lowest_terms_q.size() == 0) staged_live = 1'b0;
          end
          ENTRY_HOLD: begin
            in_valid <= 1'b0;
            hold_asked <= hold_asked + 1;
            staged_live = 1'b0;
          end
          ENTRY_QUIET: begin
            in_valid <= 1'b0;
            quiet_tail <= 1'b1;
            staged_live = 1'b0;
          end
          default: begin
            if (staged.gap != 0) begin
              in_valid <= 1'b0;
              staged.gap = staged.gap - 1'b1;
            end else begin
              in_valid <= 1'b1;
              in_numerator <= staged.num;
              in_denominator <= staged.den;
              staged_live = 1'b0;
            end
          end
        endcase
      end
    end
  end

  // receiver: stall bursts whose density is redrawn at random,
  // plus the one long hold-off that fills the block up
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle = rx_cycle + 1;
      if (rx_cycle % 256 == 0) rx_mode = idle_mode_e'($urandom_range(0, 2));
      if (hold_asked != hold_served) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_served = hold_served + 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap = rx_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet_tail && pick_gap(rx_mode) != 0) begin
        rx_gap = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on every accepted item, check every accepted result
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      lowest_terms_q.push_back(reduce_fraction(in_numerator, in_denominator));
      n_sent = n_sent + 1;
      if (in_denominator == 0) n_zero_den = n_zero_den + 1;
      else if (in_numerator == 0) n_zero_num = n_zero_num + 1;
      if (in_numerator == MOST_NEG || in_denominator == MOST_NEG)
        n_most_neg = n_most_neg + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (lowest_terms_q.size() == 0) begin
        $error("result with no item outstanding: %0d / %0d",
               $signed(out_reduced_numerator), out_reduced_denominator);
        errors = errors + 1;
      end else begin
        want = lowest_terms_q.pop_front();
        n_checked = n_checked + 1;
        if (out_reduced_numerator !== want.num) begin
          $error("reduced_numerator: expected %0d, got %0d",
                 $signed(want.num), $signed(out_reduced_numerator));
          errors = errors + 1;
        end
        if (out_reduced_denominator !== want.den) begin
          $error("reduced_denominator: expected %0d, got %0d",
                 want.den, out_reduced_denominator);
          errors = errors + 1;
        end
        if (out_zero_denominator !== want.zero_den) begin
          $error("zero_denominator: expected %0d, got %0d",
                 want.zero_den, out_zero_denominator);
          errors = errors + 1;
        end
      end
    end
  end

  // stimulus plan, then wait for the last result and report
  initial begin
    logic [W-1:0] n;
    logic [W-1:0] d;
    idle_mode_e   mode;

    // directed corners: zeros, signs, extremes, most negative value
    add_pair(0, 0, 0);
    add_pair(5, 0, 0);
    add_pair(-5, 0, 0);
    add_pair(MOST_NEG, 0, 0);
    add_pair(0, 7, 0);
    add_pair(0, -7, 0);
    add_pair(6, 4, 0);
    add_pair(-6, 4, 0);
    add_pair(6, -4, 0);
    add_pair(-6, -4, 0);
    add_pair(12, -18, 0);
    add_pair(MAX_MAG, MAX_MAG, 0);
    add_pair(~MAX_MAG + 1'b1, MAX_MAG, 0);
    add_pair(MAX_MAG, MAX_MAG - 1'b1, 0);
    add_pair(1, MAX_MAG, 0);
    add_pair(MOST_NEG, 1, 0);
    add_pair(MOST_NEG, -1, 0);
    add_pair(MOST_NEG, 2, 0);
    add_pair(MOST_NEG, 3, 0);
    add_pair(MOST_NEG, MOST_NEG, 0);
    add_pair(1, MOST_NEG, 0);
    add_pair(-3, MOST_NEG, 0);
    add_pair(32'h4000_0000, MOST_NEG, 0);
    add_pair(7, 1, 0);
    add_marker(ENTRY_DRAIN);

    for (int s = 0; s < SEGMENTS; s++) begin
      mode = idle_mode_e'($urandom_range(0, 2));
      if (s == 3) begin
        // sender keeps pushing back to back while the receiver holds off
        add_marker(ENTRY_HOLD);
        mode = IDLE_NONE;
      end
      if (s == SEGMENTS - 1) begin
        add_marker(ENTRY_QUIET);
        mode = IDLE_NONE;
      end
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        random_fraction(n, d);
        add_pair(n, d, pick_gap(mode));
      end
      if (s == 1 || s == 5 || s == 8) add_marker(ENTRY_DRAIN);
    end

    @(posedge clk);
    while (fraction_q.size() != 0 || staged_live || in_valid) @(posedge clk);
    while (lowest_terms_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d fractions: %0d zero denominators, %0d zero numerators,",
             n_sent, n_zero_den, n_zero_num);
    $display("%0d with the most negative value, %0d results checked, %0d errors",
             n_most_neg, n_checked, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10ms;
    $display("timeout with %0d results outstanding", lowest_terms_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
